[sv/zcf_pkg.sv]
// shared types, constants and helpers of the z-machine call frame unit
package zcf_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned PAGE_BYTES  = 512;

  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned FP_W  = 17;
  localparam int unsigned PC_W  = 20;
  localparam int unsigned WORD_W = 16;

  localparam int unsigned FRAME_WORDS = 4;
  localparam int unsigned KIND_BIT    = 8;
  localparam logic [3:0]  LAST_CODE_DEFAULT_VERSION = 4'd4;

  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] PAGE_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(PAGE_BYTES));

  localparam logic [1:0] CFG_STORY_VERSION = 2'd0;
  localparam logic [1:0] CFG_ADDRESS_SCALE = 2'd1;

  typedef enum logic [2:0] {
    CMD_RESTART = 3'd0,
    CMD_CALL    = 3'd1,
    CMD_LOCAL   = 3'd2,
    CMD_RETURN  = 3'd3,
    CMD_CATCH   = 3'd4,
    CMD_THROW   = 3'd5,
    CMD_CHECK   = 3'd6,
    CMD_JUMP    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_FRAME = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALL0,
    ST_CALL1,
    ST_CALL2,
    ST_CALL3,
    ST_POP1,
    ST_POP2,
    ST_POP3,
    ST_POP4,
    ST_CHECK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [15:0] address;
    logic        call_kind;
    logic [2:0]  arg_count;
    logic [3:0]  local_count;
    logic [15:0] value;
    logic [15:0] default_value;
    logic [9:0]  frame_index;
  } zcf_in_t;

  typedef struct packed {
    logic [19:0] new_pc;
    logic        store_valid;
    logic [15:0] store_value;
    logic        branch_taken;
    err_e        error_code;
  } zcf_out_t;

  function automatic logic frame_ok(input logic [FP_W-1:0] fp);
    logic [FP_W-1:0] top;
    top = fp + FP_W'(FRAME_WORDS);
    return top < FP_W'(STACK_DEPTH);
  endfunction

endpackage

[sv/zcf_page_split.sv]
// two-stage split of the program counter into page and offset
module zcf_page_split import zcf_pkg::*; (
  input  logic              clk_i,
  input  logic [PC_W-1:0]   pc_i,
  output logic [WORD_W-1:0] page_o,
  output logic [WORD_W-1:0] off_o
);

  logic [PC_W+RECIP_W-1:0] prod;
  logic [PC_W-1:0]         quot_q;
  logic [PC_W-1:0]         pc1_q;
  logic [PC_W-1:0]         rem;

  assign prod = (PC_W+RECIP_W)'(pc_i) * (PC_W+RECIP_W)'(PAGE_RECIP);
  assign rem  = pc1_q - quot_q * PC_W'(PAGE_BYTES);

  always_ff @(posedge clk_i) begin
    quot_q <= prod[RECIP_SHIFT +: PC_W];
    pc1_q  <= pc_i;
    if (rem >= PC_W'(PAGE_BYTES)) begin
      page_o <= WORD_W'(quot_q + PC_W'(1));
      off_o  <= WORD_W'(rem - PC_W'(PAGE_BYTES));
    end else begin
      page_o <= WORD_W'(quot_q);
      off_o  <= WORD_W'(rem);
    end
  end

endmodule

[sv/zmachine_call_frame_unit.sv]
// top level of the z-machine call frame unit
// One item is in work at a time and the stack lives in a single-port RAM with a registered
// read, one word per cycle. Every item ends in ST_FINISH; an argument check that reads its
// frame word passes ST_CHECK before it, a call that pushes a frame ST_CALL0 to ST_CALL3
// for its four frame-word writes, and a return or throw that finds its frame ST_POP1 to
// ST_POP4 for its four frame-word reads. The next item is taken once the result sits in the
// output register, even while it still waits. The stack needs no clearing after reset.
module zmachine_call_frame_unit import zcf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  zcf_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output zcf_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_data_i
);

  state_e            state_q, state_d;
  logic [SP_W-1:0]   sp_q, sp_d;
  logic [FP_W-1:0]   fp_q, fp_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic [3:0]        locals_q, locals_d;
  logic [2:0]        args_q, args_d;
  logic [3:0]        ver_q, scale_q;

  logic [FP_W-1:0]   base_q, base_d;
  logic              kind_q, kind_d;
  logic [2:0]        argc_q, argc_d;
  logic [3:0]        nloc_q, nloc_d;
  logic [15:0]       addr_q, addr_d;
  logic [15:0]       value_q, value_d;
  logic [15:0]       page_q, page_d;
  logic [PC_W-1:0]   pop_pc_q, pop_pc_d;

  logic              res_store_q, res_store_d;
  logic [15:0]       res_val_q, res_val_d;
  logic              res_branch_q, res_branch_d;
  err_e              res_err_q, res_err_d;

  logic              out_valid_q, out_valid_d;
  zcf_out_t          out_q, out_d;

  logic [15:0]       mem [STACK_DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [15:0]       mem_wdata;
  logic [15:0]       rdata_q;

  logic [WORD_W-1:0] split_page, split_off;
  logic              accept, out_free;
  logic [FP_W-1:0]   target;
  logic [15:0]       local_word;

  zcf_page_split u_split (
    .clk_i  (clk_i),
    .pc_i   (pc_q),
    .page_o (split_page),
    .off_o  (split_off)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;
  assign target      = FP_W'(in_data_i.frame_index);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  always_comb begin
    state_d      = state_q;
    sp_d         = sp_q;
    fp_d         = fp_q;
    pc_d         = pc_q;
    locals_d     = locals_q;
    args_d       = args_q;
    base_d       = base_q;
    kind_d       = kind_q;
    argc_d       = argc_q;
    nloc_d       = nloc_q;
    addr_d       = addr_q;
    value_d      = value_q;
    page_d       = page_q;
    pop_pc_d     = pop_pc_q;
    res_store_d  = res_store_q;
    res_val_d    = res_val_q;
    res_branch_d = res_branch_q;
    res_err_d    = res_err_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mem_we       = 1'b0;
    mem_addr     = '0;
    mem_wdata    = '0;
    local_word   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_store_d  = 1'b0;
          res_val_d    = '0;
          res_branch_d = 1'b0;
          res_err_d    = ERR_NONE;
          state_d      = ST_FINISH;
          case (in_data_i.command)
            CMD_RESTART: begin
              pc_d     = PC_W'(in_data_i.address);
              sp_d     = SP_W'(STACK_DEPTH);
              fp_d     = FP_W'(STACK_DEPTH - 1);
              locals_d = '0;
              args_d   = '0;
            end
            CMD_CALL: begin
              if (in_data_i.address == '0) begin
                locals_d    = '0;
                args_d      = '0;
                res_store_d = in_data_i.call_kind;
              end else if (sp_q < SP_W'(FRAME_WORDS)) begin
                locals_d  = '0;
                args_d    = '0;
                res_err_d = ERR_OVERFLOW;
              end else begin
                kind_d  = in_data_i.call_kind;
                argc_d  = in_data_i.arg_count;
                nloc_d  = in_data_i.local_count;
                addr_d  = in_data_i.address;
                state_d = ST_CALL0;
              end
            end
            CMD_LOCAL: begin
              if (locals_q != '0) begin
                if (args_q != '0) begin
                  local_word = in_data_i.value;
                  args_d     = args_q - 3'd1;
                end else if (ver_q > LAST_CODE_DEFAULT_VERSION) begin
                  local_word = '0;
                end else begin
                  local_word = in_data_i.default_value;
                end
                if (ver_q <= LAST_CODE_DEFAULT_VERSION) begin
                  pc_d = pc_q + PC_W'(2);
                end
                locals_d = locals_q - 4'd1;
                if (sp_q == '0) begin
                  res_err_d = ERR_OVERFLOW;
                end else begin
                  sp_d      = sp_q - SP_W'(1);
                  mem_we    = 1'b1;
                  mem_addr  = AW'(sp_q - SP_W'(1));
                  mem_wdata = local_word;
                end
              end
            end
            CMD_RETURN: begin
              if (frame_ok(fp_q)) begin
                base_d   = fp_q;
                value_d  = in_data_i.value;
                mem_addr = AW'(fp_q + FP_W'(1));
                state_d  = ST_POP1;
              end else begin
                res_err_d = ERR_NO_FRAME;
              end
            end
            CMD_CATCH: begin
              if (ver_q > LAST_CODE_DEFAULT_VERSION) begin
                res_store_d = 1'b1;
                res_val_d   = fp_q[15:0];
              end else if (sp_q < SP_W'(STACK_DEPTH)) begin
                sp_d = sp_q + SP_W'(1);
              end
            end
            CMD_THROW: begin
              if (target > fp_q || !frame_ok(target)) begin
                res_err_d = ERR_NO_FRAME;
              end else begin
                base_d   = target;
                value_d  = in_data_i.value;
                mem_addr = AW'(target + FP_W'(1));
                state_d  = ST_POP1;
              end
            end
            CMD_CHECK: begin
              argc_d = in_data_i.arg_count;
              if (frame_ok(fp_q) || (FP_W'(fp_q + FP_W'(1)) < FP_W'(STACK_DEPTH))) begin
                mem_addr = AW'(fp_q + FP_W'(1));
                state_d  = ST_CHECK;
              end else begin
                res_branch_d = (in_data_i.arg_count == '0);
              end
            end
            CMD_JUMP: begin
              pc_d = pc_q + {{(PC_W-16){in_data_i.value[15]}}, in_data_i.value} - PC_W'(2);
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_CALL0: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(sp_q - SP_W'(3));
        mem_wdata = fp_q[15:0];
        state_d   = ST_CALL1;
      end
      ST_CALL1: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(sp_q - SP_W'(4));
        mem_wdata = 16'(argc_q) | (16'(kind_q) << KIND_BIT);
        state_d   = ST_CALL2;
      end
      ST_CALL2: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(sp_q - SP_W'(1));
        mem_wdata = split_page;
        state_d   = ST_CALL3;
      end
      ST_CALL3: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(sp_q - SP_W'(2));
        mem_wdata = split_off;
        sp_d      = sp_q - SP_W'(FRAME_WORDS);
        fp_d      = FP_W'(sp_q) - FP_W'(FRAME_WORDS + 1);
        pc_d      = PC_W'(addr_q) * PC_W'(scale_q) + PC_W'(1);
        locals_d  = nloc_q;
        args_d    = argc_q;
        state_d   = ST_FINISH;
      end
      ST_POP1: begin
        kind_d   = rdata_q[KIND_BIT];
        mem_addr = AW'(base_q + FP_W'(4));
        state_d  = ST_POP2;
      end
      ST_POP2: begin
        page_d   = rdata_q;
        mem_addr = AW'(base_q + FP_W'(3));
        state_d  = ST_POP3;
      end
      ST_POP3: begin
        pop_pc_d = PC_W'(page_q) * PC_W'(PAGE_BYTES) + PC_W'(rdata_q);
        mem_addr = AW'(base_q + FP_W'(2));
        state_d  = ST_POP4;
      end
      ST_POP4: begin
        fp_d        = FP_W'(rdata_q);
        sp_d        = SP_W'(base_q + FP_W'(FRAME_WORDS + 1));
        pc_d        = pop_pc_q;
        res_store_d = kind_q;
        res_val_d   = kind_q ? value_q : '0;
        state_d     = ST_FINISH;
      end
      ST_CHECK: begin
        res_branch_d = (8'(argc_q) <= rdata_q[7:0]);
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.new_pc       = pc_q;
          out_d.store_valid  = res_store_q;
          out_d.store_value  = res_val_q;
          out_d.branch_taken = res_branch_q;
          out_d.error_code   = res_err_q;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sp_q        <= SP_W'(STACK_DEPTH);
      fp_q        <= FP_W'(STACK_DEPTH - 1);
      pc_q        <= '0;
      locals_q    <= '0;
      args_q      <= '0;
      ver_q       <= 4'd3;
      scale_q     <= 4'd2;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      fp_q        <= fp_d;
      pc_q        <= pc_d;
      locals_q    <= locals_d;
      args_q      <= args_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_STORY_VERSION: ver_q   <= cfg_data_i;
          CFG_ADDRESS_SCALE: scale_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q       <= base_d;
    kind_q       <= kind_d;
    argc_q       <= argc_d;
    nloc_q       <= nloc_d;
    addr_q       <= addr_d;
    value_q      <= value_d;
    page_q       <= page_d;
    pop_pc_q     <= pop_pc_d;
    res_store_q  <= res_store_d;
    res_val_q    <= res_val_d;
    res_branch_q <= res_branch_d;
    res_err_q    <= res_err_d;
    out_q        <= out_d;
  end

  a_mem_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_addr) < STACK_DEPTH))
    else $error("stack write outside the memory");

  a_item_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted item produced no work");

  a_pc_stable_in_call: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALL0 || state_q == ST_CALL1 || state_q == ST_CALL2) |=> $stable(pc_q))
    else $error("pc moved while its page split was pending");

  a_finish_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished result not loaded into the output register");

endmodule
